FILE: rtl/core/nmea_chk_pkg.sv
`timescale 1ns / 1ps

package nmea_chk_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam int HDR_LEN   = 5;
    localparam int COMMA_POS = 6;
    localparam int MIN_LEN   = 10;

    localparam logic [2:0] TALKER_GPS      = 3'd0;
    localparam logic [2:0] TALKER_GLONASS  = 3'd1;
    localparam logic [2:0] TALKER_GALILEO  = 3'd2;
    localparam logic [2:0] TALKER_BEIDOU   = 3'd3;
    localparam logic [2:0] TALKER_COMBINED = 3'd4;
    localparam logic [2:0] TALKER_INVALID  = 3'd5;

    localparam logic [2:0] KIND_GGA   = 3'd0;
    localparam logic [2:0] KIND_GLL   = 3'd1;
    localparam logic [2:0] KIND_GSA   = 3'd2;
    localparam logic [2:0] KIND_RMC   = 3'd3;
    localparam logic [2:0] KIND_VTG   = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    typedef logic [HDR_LEN-1:0][7:0] header_t;

    typedef struct packed {
        logic [7:0] xor_acc;
        header_t    hdr;
        logic       header_good;
        logic       star_seen;
        logic [1:0] after_star_cnt;
        logic       pair_good;
        logic       hex_active;
        logic [7:0] recv_val;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        xor_acc:        8'h00,
        hdr:            '0,
        header_good:    1'b1,
        star_seen:      1'b0,
        after_star_cnt: 2'd0,
        pair_good:      1'b1,
        hex_active:     1'b0,
        recv_val:       8'h00
    };

    typedef struct packed {
        logic       format_ok;
        logic       checksum_ok;
        logic [2:0] talker;
        logic [2:0] sentence_kind;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [7:0] line_length;
    } report_t;

    // Top bit set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b inside {[8'h30:8'h39]}) v = {1'b0, 4'(b - 8'h30)};
        else if (b inside {[8'h41:8'h46]}) v = {1'b0, 4'(b - 8'h37)};
        else if (b inside {[8'h61:8'h66]}) v = {1'b0, 4'(b - 8'h57)};
        return v;
    endfunction

    function automatic logic [2:0] decode_talker(input header_t h);
        logic [2:0] t;
        t = TALKER_INVALID;
        if (h[0] == "G" && h[1] == "P") t = TALKER_GPS;
        else if (h[0] == "G" && h[1] == "L") t = TALKER_GLONASS;
        else if (h[0] == "G" && h[1] == "A") t = TALKER_GALILEO;
        else if ((h[0] == "G" && h[1] == "B") || (h[0] == "B" && h[1] == "D"))
            t = TALKER_BEIDOU;
        else if (h[0] == "G" && h[1] == "N") t = TALKER_COMBINED;
        return t;
    endfunction

    function automatic logic type_is(input header_t h, input logic [23:0] s);
        return h[2] == s[23:16] && h[3] == s[15:8] && h[4] == s[7:0];
    endfunction

    function automatic logic [2:0] decode_kind(input header_t h);
        logic [2:0] k;
        k = KIND_OTHER;
        if (type_is(h, "GGA")) k = KIND_GGA;
        else if (type_is(h, "GLL")) k = KIND_GLL;
        else if (type_is(h, "GSA")) k = KIND_GSA;
        else if (type_is(h, "RMC")) k = KIND_RMC;
        else if (type_is(h, "VTG")) k = KIND_VTG;
        return k;
    endfunction

endpackage

FILE: rtl/core/nmea_chk_byte_if.sv
`timescale 1ns / 1ps

interface nmea_chk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

FILE: rtl/core/nmea_chk_report_if.sv
`timescale 1ns / 1ps

interface nmea_chk_report_if;
    logic       valid;
    logic       ready;
    logic       format_ok;
    logic       checksum_ok;
    logic [2:0] talker;
    logic [2:0] sentence_kind;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] line_length;

    modport source (output valid, output format_ok, output checksum_ok, output talker,
                    output sentence_kind, output computed_sum, output received_sum,
                    output line_length, input ready);
    modport sink (input valid, input format_ok, input checksum_ok, input talker,
                  input sentence_kind, input computed_sum, input received_sum,
                  input line_length, output ready);
endinterface

FILE: rtl/core/nmea_chk_line.sv
`timescale 1ns / 1ps

module nmea_chk_line #(
    parameter int POS_LIMIT = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    output logic                 report_valid,
    output nmea_chk_pkg::report_t report
);
    import nmea_chk_pkg::*;

    localparam int PW = $clog2(POS_LIMIT + 1);

    line_state_t   state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          cr_reg, cr_next;

    line_state_t   s1;
    logic [PW-1:0] p1;
    logic          fmt;

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        return (p < PW'(POS_LIMIT)) ? p + PW'(1) : p;
    endfunction

    function automatic line_state_t absorb(input line_state_t s, input logic [PW-1:0] p,
                                           input logic [7:0] b);
        line_state_t r;
        logic [4:0]  hv;
        r  = s;
        hv = hex_value(b);
        if (p == '0)
        begin
            if (b != CHAR_DOLLAR) r.header_good = 1'b0;
        end
        else if (p <= PW'(HDR_LEN))
        begin
            r.hdr[p[2:0] - 3'd1] = b;
            if (!(b inside {[8'h30:8'h39], [8'h41:8'h5A]})) r.header_good = 1'b0;
        end
        else if (p == PW'(COMMA_POS))
        begin
            if (b != CHAR_COMMA) r.header_good = 1'b0;
        end

        if (s.star_seen)
        begin
            if (s.after_star_cnt < 2'd2)
            begin
                r.after_star_cnt = s.after_star_cnt + 2'd1;
                if (hv[4]) r.pair_good = 1'b0;
            end
            if (s.hex_active)
            begin
                if (!hv[4]) r.recv_val = {s.recv_val[3:0], hv[3:0]};
                else r.hex_active = 1'b0;
            end
        end
        else if (b == CHAR_STAR)
        begin
            r.star_seen  = 1'b1;
            r.hex_active = 1'b1;
            r.recv_val   = 8'h00;
        end
        else if (p != '0)
        begin
            r.xor_acc = s.xor_acc ^ b;
        end
        return r;
    endfunction

    // Report fields always come from the state as it stands before this byte.
    always_comb
    begin
        fmt = state_reg.header_good && (pos_reg >= PW'(MIN_LEN)) && state_reg.star_seen
              && (state_reg.after_star_cnt == 2'd2) && state_reg.pair_good;
        report.format_ok     = fmt;
        report.checksum_ok   = fmt && (state_reg.xor_acc == state_reg.recv_val);
        report.talker        = decode_talker(state_reg.hdr);
        report.sentence_kind = decode_kind(state_reg.hdr);
        report.computed_sum  = state_reg.xor_acc;
        report.received_sum  = state_reg.recv_val;
        report.line_length   = (32'(pos_reg) > 32'd255) ? 8'hFF : 8'(pos_reg);
    end

    assign report_valid = step && cr_reg && (byte_in == CHAR_LF);

    // A held CR that is not followed by LF becomes content before the new byte.
    always_comb
    begin
        s1 = cr_reg ? absorb(state_reg, pos_reg, CHAR_CR) : state_reg;
        p1 = cr_reg ? pos_inc(pos_reg) : pos_reg;
        state_next = state_reg;
        pos_next   = pos_reg;
        cr_next    = cr_reg;
        if (step)
        begin
            if (cr_reg && byte_in == CHAR_LF)
            begin
                state_next = LINE_CLEAR;
                pos_next   = '0;
                cr_next    = 1'b0;
            end
            else if (byte_in == CHAR_CR)
            begin
                state_next = s1;
                pos_next   = p1;
                cr_next    = 1'b1;
            end
            else
            begin
                state_next = absorb(s1, p1, byte_in);
                pos_next   = pos_inc(p1);
                cr_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LINE_CLEAR;
            pos_reg   <= '0;
            cr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cr_reg    <= cr_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cr_held: assert property (@(posedge clk) disable iff (!rst_n)
        step && byte_in == CHAR_CR |=> cr_reg)
        else $error("CR not held after CR byte");
    a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |=> pos_reg == '0 && !state_reg.star_seen)
        else $error("line state not cleared after report");
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(POS_LIMIT))
        else $error("position beyond limit");
`endif

endmodule

FILE: rtl/core/nmea_sentence_checker_top.sv
`timescale 1ns / 1ps
// A report is loaded into the output register when its LF advances from the input register into the line tracker.
// Throughput: one byte per cycle while the output is not stalled; the input register feeds the line tracker.
// A stalled output holds one report and freezes the line tracker, so one more byte
// waits in the input register and the input then stalls.
// Reset (asynchronous, active low) clears the line state, the held CR and both
// valid flags; no clearing pass is needed.
module nmea_sentence_checker_top #(
    parameter int POS_LIMIT = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    nmea_chk_byte_if.sink     bytes,
    nmea_chk_report_if.source reports
);
    import nmea_chk_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    report_t    out_reg;

    logic       advance;
    logic       rep_valid;
    report_t    rep;

    assign advance     = in_valid_reg && (!out_valid_reg || reports.ready);
    assign bytes.ready = !in_valid_reg || advance;

    nmea_chk_line #(.POS_LIMIT(POS_LIMIT)) u_line (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .byte_in      (in_byte_reg),
        .report_valid (rep_valid),
        .report       (rep)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (bytes.ready) in_valid_next = bytes.valid;
        out_valid_next = out_valid_reg;
        if (advance && rep_valid) out_valid_next = 1'b1;
        else if (reports.ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid) in_byte_reg <= bytes.byte_in;
        if (advance && rep_valid) out_reg <= rep;
    end

    assign reports.valid         = out_valid_reg;
    assign reports.format_ok     = out_reg.format_ok;
    assign reports.checksum_ok   = out_reg.checksum_ok;
    assign reports.talker        = out_reg.talker;
    assign reports.sentence_kind = out_reg.sentence_kind;
    assign reports.computed_sum  = out_reg.computed_sum;
    assign reports.received_sum  = out_reg.received_sum;
    assign reports.line_length   = out_reg.line_length;

`ifndef NO_ASSERTIONS
    a_sum_needs_format: assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid |-> (!reports.checksum_ok || reports.format_ok))
        else $error("checksum flag set without format pass");
    a_short_line_fails: assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid && reports.line_length < 8'd10 |-> !reports.format_ok)
        else $error("short line passed format check");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !reports.ready |-> !advance)
        else $error("line tracker advanced into a held report");
`endif

endmodule

FILE: tb/nmea_line_report_checker.sv
`timescale 1ns / 1ps

module nmea_line_report_checker (
    input  logic       clk,
    input  logic       rst_n,
    nmea_chk_byte_if   byte_mon,
    nmea_chk_report_if report_mon,
    output int         mismatches,
    output int         outstanding,
    output int         reports_checked
);
    import nmea_chk_pkg::*;

    localparam logic [7:0] LENGTH_CAP = 8'd255;

    logic [7:0] line_pos;
    logic [7:0] line_xor;
    logic [7:0] recv_value;
    logic [7:0] hdr_bytes [HDR_LEN];
    logic       hdr_good;
    logic       star_seen;
    logic [1:0] digits_after_star;
    logic       pair_good;
    logic       hex_active;
    logic       cr_held;

    report_t    expected_reports [$];

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return {1'b0, b[3:0]};
        if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
            return {1'b0, b[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic logic [2:0] talker_of();
        case ({hdr_bytes[0], hdr_bytes[1]})
            "GP":      return TALKER_GPS;
            "GL":      return TALKER_GLONASS;
            "GA":      return TALKER_GALILEO;
            "GB", "BD": return TALKER_BEIDOU;
            "GN":      return TALKER_COMBINED;
            default:   return TALKER_INVALID;
        endcase
    endfunction

    function automatic logic [2:0] kind_of();
        case ({hdr_bytes[2], hdr_bytes[3], hdr_bytes[4]})
            "GGA":   return KIND_GGA;
            "GLL":   return KIND_GLL;
            "GSA":   return KIND_GSA;
            "RMC":   return KIND_RMC;
            "VTG":   return KIND_VTG;
            default: return KIND_OTHER;
        endcase
    endfunction

    task automatic clear_line_state();
        line_pos          = '0;
        line_xor          = '0;
        recv_value        = '0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr_bytes[i] = '0;
        hdr_good          = 1'b1;
        star_seen         = 1'b0;
        digits_after_star = '0;
        pair_good         = 1'b1;
        hex_active        = 1'b0;
        cr_held           = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [4:0] nib;
        if (line_pos == 0)
        begin
            if (b != CHAR_DOLLAR)
                hdr_good = 1'b0;
        end
        else if (line_pos <= HDR_LEN)
        begin
            hdr_bytes[line_pos - 8'd1] = b;
            if (!((b >= "0" && b <= "9") || (b >= "A" && b <= "Z")))
                hdr_good = 1'b0;
        end
        else if (line_pos == COMMA_POS)
        begin
            if (b != CHAR_COMMA)
                hdr_good = 1'b0;
        end

        // Everything after the first star is checksum text and stays out of the XOR.
        if (star_seen)
        begin
            nib = nibble_of(b);
            if (digits_after_star < 2)
            begin
                digits_after_star++;
                if (nib[4])
                    pair_good = 1'b0;
            end
            if (hex_active)
            begin
                if (!nib[4])
                    recv_value = {recv_value[3:0], nib[3:0]};
                else
                    hex_active = 1'b0;
            end
        end
        else if (b == CHAR_STAR)
        begin
            star_seen  = 1'b1;
            hex_active = 1'b1;
            recv_value = '0;
        end
        else if (line_pos != 0)
        begin
            line_xor ^= b;
        end

        if (line_pos != LENGTH_CAP)
            line_pos++;
    endtask

    task automatic take_byte(input logic [7:0] b);
        report_t r;
        if (cr_held)
        begin
            cr_held = 1'b0;
            if (b == CHAR_LF)
            begin
                r.format_ok     = hdr_good && line_pos >= MIN_LEN && star_seen &&
                                  digits_after_star == 2 && pair_good;
                r.checksum_ok   = r.format_ok && line_xor == recv_value;
                r.talker        = talker_of();
                r.sentence_kind = kind_of();
                r.computed_sum  = line_xor;
                r.received_sum  = recv_value;
                r.line_length   = line_pos;
                expected_reports.push_back(r);
                clear_line_state();
                return;
            end
            // A CR without LF turns into ordinary line content.
            absorb_byte(CHAR_CR);
        end
        if (b == CHAR_CR)
            cr_held = 1'b1;
        else
            absorb_byte(b);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("report %0d: %s is %0h, expected %0h",
                                    reports_checked, name, got, want));
    endtask

    task automatic compare_report();
        report_t want;
        if (expected_reports.size() == 0)
        begin
            note_mismatch("report arrived with no line end outstanding");
            return;
        end
        want = expected_reports.pop_front();
        check_field("format_ok", report_mon.format_ok, want.format_ok);
        check_field("checksum_ok", report_mon.checksum_ok, want.checksum_ok);
        check_field("talker", report_mon.talker, want.talker);
        check_field("sentence_kind", report_mon.sentence_kind, want.sentence_kind);
        check_field("computed_sum", report_mon.computed_sum, want.computed_sum);
        check_field("received_sum", report_mon.received_sum, want.received_sum);
        check_field("line_length", report_mon.line_length, want.line_length);
        reports_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line_state();
            expected_reports.delete();
            mismatches      = 0;
            reports_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (report_mon.valid && report_mon.ready)
                compare_report();
            if (byte_mon.valid && byte_mon.ready)
                take_byte(byte_mon.byte_in);
            outstanding = expected_reports.size();
        end
    end

endmodule

FILE: tb/tb_nmea_sentence_checker_top.sv
`timescale 1ns / 1ps

module tb_nmea_sentence_checker_top;
    import nmea_chk_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    nmea_chk_byte_if   bytes_if ();
    nmea_chk_report_if report_if ();

    int mismatches;
    int outstanding;
    int reports_checked;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_req;
    int bytes_sent;
    int lines_sent;

    logic [7:0] line_buf [$];

    nmea_sentence_checker_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .reports (report_if)
    );

    nmea_line_report_checker line_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_mon        (bytes_if),
        .report_mon      (report_if),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .reports_checked (reports_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
        if (n < 10)
            return 8'("0" + n);
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] hdr_char();
        int n;
        n = $urandom_range(0, 35);
        return (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
    endfunction

    // Printable text for the data fields, kept free of the star.
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        return (c == CHAR_STAR) ? CHAR_COMMA : c;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_sum(input bit corrupt, input bit lower);
        logic [7:0] sum;
        sum = '0;
        for (int i = 1; i < line_buf.size(); i++)
            sum ^= line_buf[i];
        if (corrupt)
            sum ^= 8'($urandom_range(1, 255));
        line_buf.push_back(CHAR_STAR);
        line_buf.push_back(hex_digit(sum[7:4], lower));
        line_buf.push_back(hex_digit(sum[3:0], lower));
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            bytes_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        bytes_if.valid   <= 1'b1;
        bytes_if.byte_in <= b;
        do
            @(posedge clk);
        while (!bytes_if.ready);
        bytes_sent++;
    endtask

    task automatic finish_line();
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic wait_for_reports();
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Output side: random back-pressure, or a long hold-off when one is requested.
    initial
    begin
        int stall_left;
        report_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                report_if.ready <= 1'b0;
                stall_left = hold_req;
                hold_req   = 0;
                while (stall_left > 0)
                begin
                    @(posedge clk);
                    stall_left--;
                end
            end
            else
            begin
                report_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Timeout with %0d reports still outstanding", outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int bytes_at_start;
        int lines_at_start;
        int pick;
        int n;

        rst_n            <= 1'b0;
        bytes_if.valid   <= 1'b0;
        bytes_if.byte_in <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 0;
        bytes_sent     = 0;
        lines_sent     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: each talker and sentence type, then the awkward cases.
        add_text("$GPGGA,123519,4807.038,N"); add_sum(0, 0); finish_line();
        add_text("$GLGLL,4916.45,N");         add_sum(0, 1); finish_line();
        add_text("$GAGSA,A,3");               add_sum(0, 0); finish_line();
        add_text("$GBRMC,225446,A");          add_sum(0, 1); finish_line();
        add_text("$BDVTG,054.7,T");           add_sum(0, 0); finish_line();
        add_text("$GNZDA,1");                 add_sum(0, 0); finish_line();
        add_text("$GPGGA,1");                 add_sum(1, 0); finish_line();
        finish_line();
        add_text("$G"); finish_line();
        add_text("$GPGGA,"); add_sum(0, 0); finish_line();
        add_text("$GPRMC,1"); line_buf.push_back(CHAR_CR); add_text("2");
        add_sum(0, 0); finish_line();
        add_text("$GPRMC,"); line_buf.push_back(CHAR_LF); add_text("3");
        add_sum(0, 1); finish_line();
        add_text("$GPGLL,"); line_buf.push_back(8'h00); add_sum(0, 0); finish_line();
        add_text("$gpgga,1"); add_sum(0, 0); finish_line();
        add_text("$GPGGA;1"); add_sum(0, 0); finish_line();
        add_text("$GPGGA,1,2,3"); finish_line();
        add_text("$GPGGA,1*4"); finish_line();
        add_text("$GPGGA,1*G1"); finish_line();
        add_text("$GPGGA,1*1234abC9"); finish_line();
        add_text("$GPGSA,9"); add_sum(0, 0); add_text("*FF"); finish_line();
        add_text("$GPGGA,1"); add_sum(0, 0); line_buf.push_back(CHAR_CR); finish_line();
        add_text("$GPGGA,");
        repeat (260) line_buf.push_back("x");
        add_sum(0, 0); finish_line();
        add_text("$GPVTG,"); line_buf.push_back(8'hFF); line_buf.push_back(8'h80);
        add_sum(0, 1); finish_line();
        add_text("$12345,6"); add_sum(0, 0); finish_line();
        wait_for_reports();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 86;
                end
                default:
                begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 31;
                end
            endcase
            bytes_at_start = bytes_sent;
            lines_at_start = lines_sent;
            while (bytes_sent - bytes_at_start < 45 || lines_sent - lines_at_start < 3)
            begin
                // Starve the output early in the free-running phase so the input backs up.
                if (phase == 0 && lines_sent - lines_at_start == 1)
                    hold_req = HOLD_CYCLES;
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    n = $urandom_range(0, 30);
                    repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    line_buf.push_back(CHAR_DOLLAR);
                    case ($urandom_range(0, 7))
                        0:       add_text("GP");
                        1:       add_text("GL");
                        2:       add_text("GA");
                        3:       add_text("GB");
                        4:       add_text("BD");
                        5:       add_text("GN");
                        default:
                        begin
                            line_buf.push_back(hdr_char());
                            line_buf.push_back(hdr_char());
                        end
                    endcase
                    case ($urandom_range(0, 6))
                        0:       add_text("GGA");
                        1:       add_text("GLL");
                        2:       add_text("GSA");
                        3:       add_text("RMC");
                        4:       add_text("VTG");
                        default: repeat (3) line_buf.push_back(hdr_char());
                    endcase
                    line_buf.push_back(CHAR_COMMA);
                    n = $urandom_range(0, 20);
                    repeat (n) line_buf.push_back(field_char());
                    add_sum($urandom_range(0, 9) == 0, $urandom_range(0, 1));
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(1, 4)) line_buf.push_back(field_char());
                    // About a quarter of the sentences are damaged in one way or another.
                    if (pick >= 80)
                    begin
                        n = $urandom_range(0, line_buf.size() - 1);
                        case ($urandom_range(0, 3))
                            0:       line_buf[n] = 8'($urandom_range(0, 255));
                            1:       line_buf = line_buf[0:n];
                            2:       line_buf.insert(n, CHAR_CR);
                            default: line_buf.insert(n, CHAR_LF);
                        endcase
                    end
                end
                finish_line();
            end
            wait_for_reports();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d bytes in %0d lines; %0d line reports checked.",
                 bytes_sent, lines_sent, reports_checked);
        $display("Covered header, checksum and CR/LF corner cases, saturating lengths, %s",
                 "random back-pressure and a long output hold-off.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/nmea_chk_pkg.sv
rtl/core/nmea_chk_byte_if.sv
rtl/core/nmea_chk_report_if.sv
rtl/core/nmea_chk_line.sv
rtl/core/nmea_sentence_checker_top.sv
tb/nmea_line_report_checker.sv
tb/tb_nmea_sentence_checker_top.sv
